// ===== rtl/hfa_pkg.sv =====
// hfa_pkg: shared types and codes for the hole fit allocator
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package hfa_pkg;

  // fixed field widths of the stream payloads
  localparam int IDX_FIELD_W  = 4;
  localparam int AMT_FIELD_W  = 24;
  localparam int MODE_W       = 2;
  localparam int COUNT_W      = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 5;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 32;

  // item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // placement policies
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLE_COUNT = 1'd1;

  // controller to datapath
  typedef struct packed {
    logic load;    // write a hole size from the input beat
    logic start;   // latch request amount, clear scan state
    logic issue;   // read the entry at the scan pointer
    logic finish;  // update chosen hole and load the result register
  } hfa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;  // pointer has reached the scan limit
    logic out_free;   // result register can take a new beat
  } hfa_sts_t;

endpackage

`default_nettype wire

// ===== rtl/hole_fit_allocator.sv =====
// a request scans min(hole_count, HOLES) entries, then the finish state loads the result register
// a request holds the input through the scan and finish states; a load beat leaves the input ready
// the scan reads one hole entry per cycle from the single read port of the size memory
// the result register lets the next beat in while a result waits on out_tready
// reset (rst_n low, synchronous) clears all holes to zero, fit_mode to best fit,
// hole_count to 16, and drops out_tvalid; no clearing pass is needed
`default_nettype none

module hole_fit_allocator
  import hfa_pkg::*;
#(
  parameter int HOLES     = 16,
  parameter int SIZE_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // hole_index[3:0], amount[27:4], zero pad
  input  wire logic                  in_tuser,   // kind
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // chosen_hole[3:0], space_left[27:4], zero pad
  output logic                       out_tuser,  // granted
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  hfa_cmd_t cmd;
  hfa_sts_t sts;

  logic [MODE_W-1:0]      fit_mode_r;
  logic [COUNT_W-1:0]     hole_count_r;
  logic                   out_granted;
  logic [IDX_FIELD_W-1:0] out_chosen_hole;
  logic [AMT_FIELD_W-1:0] out_space_left;

  // configuration registers; the user must write them only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r   <= FIT_BEST;
      hole_count_r <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIT_MODE:   fit_mode_r   <= cfg_wdata[MODE_W-1:0];
        CFG_HOLE_COUNT: hole_count_r <= cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer: idle / scan / finish
  hfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // memory, compare stage (first/best/worst fit) and result register
  hfa_datapath #(
    .HOLES     (HOLES),
    .SIZE_BITS (SIZE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_hole_index   (in_tdata[3:0]),
    .in_amount       (in_tdata[27:4]),
    .fit_mode        (fit_mode_r),
    .hole_count      (hole_count_r),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_granted     (out_granted),
    .out_chosen_hole (out_chosen_hole),
    .out_space_left  (out_space_left)
  );

  // pack the result beat
  assign out_tdata = {4'd0, out_space_left, out_chosen_hole};
  assign out_tuser = out_granted;

endmodule

`default_nettype wire

// ===== rtl/hfa_ctrl.sv =====
// hfa_ctrl: sequencing state machine for load and request items
// depends on hfa_pkg (command and status structs, item kinds)
`default_nettype none

module hfa_ctrl
  import hfa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  input  wire logic     in_kind,
  output logic          in_tready,
  input  wire hfa_sts_t sts,
  output hfa_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_kind == KIND_REQUEST) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // last compare completes in the cycle that sees scan_done
        if (!sts.scan_done) begin
          cmd.issue = 1'b1;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hfa_datapath.sv =====
// hfa_datapath: hole size memory, scan compare stage and result register
// depends on hfa_pkg (command and status structs, fit mode codes)
`default_nettype none

module hfa_datapath
  import hfa_pkg::*;
#(
  parameter int HOLES     = 16,
  parameter int SIZE_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire hfa_cmd_t               cmd,
  output hfa_sts_t                    sts,
  input  wire logic [IDX_FIELD_W-1:0] in_hole_index,
  input  wire logic [AMT_FIELD_W-1:0] in_amount,
  input  wire logic [MODE_W-1:0]      fit_mode,
  input  wire logic [COUNT_W-1:0]     hole_count,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic                        out_granted,
  output logic [IDX_FIELD_W-1:0]      out_chosen_hole,
  output logic [AMT_FIELD_W-1:0]      out_space_left
);

  localparam int IDX_W = (HOLES > 1) ? $clog2(HOLES) : 1;
  localparam int LIM_W = $clog2(HOLES + 1);

  // hole size memory with per-entry valid bits (unwritten entries read zero)
  logic [SIZE_BITS-1:0] mem_r [HOLES];
  logic [HOLES-1:0]     valid_r;
  logic [SIZE_BITS-1:0] rd_data_r;
  logic                 rd_hit_r;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic                 load_ok;

  // scan state
  logic [LIM_W-1:0]     limit;
  logic [LIM_W-1:0]     ptr_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 rd_vld_r;
  logic [SIZE_BITS-1:0] amt_r;
  logic                 found_r;
  logic [IDX_W-1:0]     pick_r;
  logic [SIZE_BITS-1:0] best_r;
  logic [SIZE_BITS-1:0] cur;
  logic                 fits;
  logic                 take;
  logic [SIZE_BITS-1:0] remain;

  // result register
  logic                   out_valid_r;
  logic                   granted_r;
  logic [IDX_FIELD_W-1:0] chosen_r;
  logic [AMT_FIELD_W-1:0] left_r;

  always_comb begin
    if ({27'd0, hole_count} > 32'(HOLES)) begin
      limit = LIM_W'(HOLES);
    end else begin
      limit = LIM_W'(hole_count);
    end
  end

  assign load_ok = cmd.load && ({28'd0, in_hole_index} < 32'(HOLES));
  assign remain  = best_r - amt_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pick_r;
    wr_data = remain;
    if (load_ok) begin
      wr_en   = 1'b1;
      wr_addr = IDX_W'(in_hole_index);
      wr_data = SIZE_BITS'(in_amount);
    end else if (cmd.finish && found_r) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (cmd.issue) begin
      rd_data_r <= mem_r[ptr_r[IDX_W-1:0]];
      rd_hit_r  <= valid_r[ptr_r[IDX_W-1:0]];
      rd_idx_r  <= ptr_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // compare stage
  assign cur  = rd_hit_r ? rd_data_r : '0;
  assign fits = rd_vld_r && (cur >= amt_r);

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else if (fit_mode == FIT_BEST) begin
        take = cur < best_r;
      end else if (fit_mode == FIT_WORST) begin
        take = cur > best_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.start) begin
        ptr_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.issue) begin
          ptr_r <= ptr_r + 1'b1;
        end
        if (take) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      amt_r <= SIZE_BITS'(in_amount);
    end
    if (take) begin
      pick_r <= rd_idx_r;
      best_r <= cur;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      granted_r <= found_r;
      chosen_r  <= found_r ? IDX_FIELD_W'(pick_r) : '0;
      left_r    <= found_r ? AMT_FIELD_W'(remain) : '0;
    end
  end

  assign sts.scan_done   = (ptr_r == limit);
  assign sts.out_free    = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_granted     = granted_r;
  assign out_chosen_hole = chosen_r;
  assign out_space_left  = left_r;

endmodule

`default_nettype wire

// ===== rtl/hfa_checker.sv =====
// hfa_checker: port-level checks for the hole fit allocator
// depends on hfa_pkg; bound to hole_fit_allocator at the end of this file
`default_nettype none

module hfa_checker
  import hfa_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // refused request carries zero hole and zero space
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("refused result with nonzero payload");

  // a request occupies the input side while it scans
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == KIND_REQUEST) |=> !in_tready)
    else $error("input ready right after a request beat");

  // a load on an otherwise quiet block makes no result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == KIND_LOAD) && !out_tvalid |=> !out_tvalid)
    else $error("load beat produced a result");

  // reset drops the result stream
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind hole_fit_allocator hfa_checker u_hfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== test/tb.sv =====
// tb: self-checking bench for the hole fit allocator (first, best and worst fit placement)
// drives load and request beats, predicts each grant and compares it with the result stream
// depends on rtl/hfa_pkg.sv and rtl/hole_fit_allocator.sv
`timescale 1ns / 100ps

module tb
  import hfa_pkg::*;
;

  localparam int HOLES      = 16;
  localparam int ITEM_GOAL  = 1350;
  localparam int IDLE_LIMIT = 2000;  // cycles without any accepted beat
  localparam int SETTLE     = 24;    // longest scan (16 holes) plus update, with margin

  // mode 3 has no name in the package; it places like first fit
  localparam logic [MODE_W-1:0] FIT_SPARE = 2'd3;

  typedef struct packed {
    logic                   granted;
    logic [IDX_FIELD_W-1:0] hole;
    logic [AMT_FIELD_W-1:0] left;
  } grant_t;

  // ---------------------------------------------------------------------------
  // hole table predictor and queue of owed grants
  // ---------------------------------------------------------------------------
  class hole_scoreboard;
    bit [AMT_FIELD_W-1:0] hole_size [HOLES];
    bit [MODE_W-1:0]      fit_mode;
    bit [COUNT_W-1:0]     hole_count;
    grant_t               owed_q [$];
    int                   errors;

    function new();
      foreach (hole_size[i]) hole_size[i] = '0;
      fit_mode   = FIT_BEST;
      hole_count = COUNT_W'(HOLES);
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      if (index == CFG_FIT_MODE) begin
        fit_mode = value[MODE_W-1:0];
      end else begin
        hole_count = value[COUNT_W-1:0];
      end
    endfunction

    // called once per accepted input beat
    function void note_input(logic kind, logic [IDX_FIELD_W-1:0] idx,
                             logic [AMT_FIELD_W-1:0] amt);
      int     scan_end;
      int     pick;
      bit     found;
      grant_t res;
      if (kind == KIND_LOAD) begin
        hole_size[idx] = amt;
        return;
      end
      scan_end = (hole_count > HOLES) ? HOLES : int'(hole_count);
      found    = 1'b0;
      pick     = 0;
      for (int j = 0; j < scan_end; j++) begin
        if (hole_size[j] < amt) continue;
        if (!found) begin
          found = 1'b1;
          pick  = j;
          if (fit_mode == FIT_FIRST || fit_mode == FIT_SPARE) break;
        end else if (fit_mode == FIT_BEST) begin
          if (hole_size[j] < hole_size[pick]) pick = j;
        end else if (fit_mode == FIT_WORST) begin
          if (hole_size[j] > hole_size[pick]) pick = j;
        end
      end
      res = '0;
      if (found) begin
        hole_size[pick] = hole_size[pick] - amt;
        res.granted     = 1'b1;
        res.hole        = IDX_FIELD_W'(pick);
        res.left        = hole_size[pick];
      end
      owed_q.push_back(res);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic granted, logic [IDX_FIELD_W-1:0] hole,
                               logic [AMT_FIELD_W-1:0] left);
      grant_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result beat granted=%0d hole=%0d left=%h",
                         granted, hole, left));
        return;
      end
      want = owed_q.pop_front();
      if (want.granted !== granted || want.hole !== hole || want.left !== left) begin
        report($sformatf("grant differs: expected granted=%0d hole=%0d left=%h, got granted=%0d hole=%0d left=%h",
                         want.granted, want.hole, want.left, granted, hole, left));
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // anything still owed at the end is a miss
    function void close();
      while (owed_q.size() != 0) begin
        void'(owed_q.pop_front());
        report("result beat never arrived");
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset, block under test
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // hole_index[3:0], amount[27:4], zero pad
  logic                  in_tuser;   // kind
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // chosen_hole[3:0], space_left[27:4], zero pad
  logic                  out_tuser;  // granted
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  hole_fit_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  hole_scoreboard sb;
  bit             calm;       // phase with no gaps and no stalls
  int             items_sent;
  int             ready_hold;
  int             idle_cycles;

  // ---------------------------------------------------------------------------
  // result side: check each beat, then pick the next ready level
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    int r;
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tuser, out_tdata[IDX_FIELD_W-1:0],
                      out_tdata[IDX_FIELD_W +: AMT_FIELD_W]);
    end
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_tready <= 1'b1;
        ready_hold = $urandom_range(0, 6);
      end else if (r < 90) begin
        out_tready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else begin
        // long back-pressure now and then
        out_tready <= 1'b0;
        ready_hold = $urandom_range(8, 40);
      end
    end
  end

  // watchdog: stop a hung run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input beat; tvalid stays high on return so a following beat can go
  // out with no gap
  task automatic send_beat(logic kind, logic [IDX_FIELD_W-1:0] idx,
                           logic [AMT_FIELD_W-1:0] amt);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_DATA_W - IDX_FIELD_W - AMT_FIELD_W){1'b0}}, amt, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(kind, idx, amt);
    items_sent++;
  endtask

  // block idle: no beat pending and every owed grant delivered; loads give no
  // result, so allow one full scan on top
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(index, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // request sizes lean on what the table holds: exact fits, one over, one under
  function automatic logic [AMT_FIELD_W-1:0] request_amount();
    int                   r;
    logic [AMT_FIELD_W-1:0] base;
    r    = $urandom_range(0, 99);
    base = sb.hole_size[$urandom_range(0, HOLES - 1)];
    if (r < 5)  return '0;
    if (r < 35) return base;
    if (r < 50) return base + 1'b1;
    if (r < 60) return base - 1'b1;
    if (r < 80) return AMT_FIELD_W'($urandom_range(1, 2000));
    if (r < 92) return AMT_FIELD_W'($urandom);
    return '1;
  endfunction

  // hole sizes: small, duplicated (ties), near full scale, anything
  function automatic logic [AMT_FIELD_W-1:0] load_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return AMT_FIELD_W'($urandom_range(0, 4000));
    if (r < 60) return sb.hole_size[$urandom_range(0, HOLES - 1)];
    if (r < 75) return '1 - AMT_FIELD_W'($urandom_range(0, 3));
    if (r < 92) return AMT_FIELD_W'($urandom);
    return '0;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 12) return CFG_DATA_W'(1);
    if (r < 20) return CFG_DATA_W'(HOLES);
    if (r < 25) return '1;
    if (r < 30) return CFG_DATA_W'($urandom_range(HOLES + 1, 30));
    return CFG_DATA_W'($urandom_range(2, HOLES - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // directed cases: empty table, zero request, ties, exact fits, every mode,
  // hole_count of zero, one and past the table, loads beyond the scan range
  // ---------------------------------------------------------------------------
  task automatic run_directed();
    send_beat(KIND_REQUEST, 4'd0, 24'd5);         // empty table: refused
    send_beat(KIND_REQUEST, 4'd9, 24'd0);         // zero request on zero holes: granted
    send_beat(KIND_LOAD, 4'd0, 24'hFFFFFF);
    send_beat(KIND_LOAD, 4'd15, 24'd100);
    send_beat(KIND_LOAD, 4'd7, 24'd100);          // tie with hole 15
    send_beat(KIND_LOAD, 4'd3, 24'd50);
    send_beat(KIND_LOAD, 4'd10, 24'hAAAAAA);
    send_beat(KIND_REQUEST, 4'd15, 24'd60);       // best fit tie goes low
    send_beat(KIND_REQUEST, 4'd0, 24'hFFFFFF);    // exact fit, hole drops to zero
    send_beat(KIND_REQUEST, 4'd5, 24'h555555);
    quiesce();
    write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_FIRST));
    send_beat(KIND_REQUEST, 4'd0, 24'd10);
    send_beat(KIND_REQUEST, 4'd0, 24'd41);
    quiesce();
    write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_WORST));
    send_beat(KIND_REQUEST, 4'd0, 24'd1);
    send_beat(KIND_REQUEST, 4'd0, 24'd0);
    quiesce();
    write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_SPARE));
    send_beat(KIND_REQUEST, 4'd0, 24'd20);
    quiesce();
    write_reg(CFG_HOLE_COUNT, '0);               // nothing scanned
    send_beat(KIND_REQUEST, 4'd0, 24'd0);
    quiesce();
    write_reg(CFG_HOLE_COUNT, CFG_DATA_W'(1));
    send_beat(KIND_LOAD, 4'd9, 24'd1000);         // outside the scan range
    send_beat(KIND_REQUEST, 4'd0, 24'd500);
    quiesce();
    write_reg(CFG_HOLE_COUNT, '1);               // past the table: scan all
    write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_BEST));
    send_beat(KIND_REQUEST, 4'd0, 24'd500);
    send_beat(KIND_REQUEST, 4'd0, 24'hFFFFFF);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int scan;
    int n_load;
    int n_req;
    logic [IDX_FIELD_W-1:0] idx;

    sb          = new();
    calm        = 1'b0;
    items_sent  = 0;
    ready_hold  = 0;
    idle_cycles = 0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= KIND_LOAD;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_FIT_MODE;
    cfg_wdata  <= '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // random phases: new settings, fill some holes, then a burst of requests
    while (items_sent < ITEM_GOAL) begin
      quiesce();
      write_reg(CFG_FIT_MODE, ($urandom_range(0, 9) == 0) ?
                CFG_DATA_W'(FIT_SPARE) : CFG_DATA_W'($urandom_range(0, 2)));
      write_reg(CFG_HOLE_COUNT, pick_count());
      calm = ($urandom_range(0, 4) == 0);
      scan = (sb.hole_count > HOLES) ? HOLES : int'(sb.hole_count);

      n_load = $urandom_range(1, scan + 2);
      repeat (n_load) begin
        if (scan > 0 && $urandom_range(0, 99) < 85) begin
          idx = IDX_FIELD_W'($urandom_range(0, scan - 1));
        end else begin
          idx = IDX_FIELD_W'($urandom_range(0, HOLES - 1));
        end
        send_beat(KIND_LOAD, idx, load_amount());
      end

      n_req = $urandom_range(1, 14);
      repeat (n_req) begin
        // index is don't-care for requests, so it toggles freely
        if ($urandom_range(0, 9) == 0) begin
          send_beat(KIND_LOAD, IDX_FIELD_W'($urandom), AMT_FIELD_W'($urandom));
        end else begin
          send_beat(KIND_REQUEST, IDX_FIELD_W'($urandom), request_amount());
        end
      end
    end

    quiesce();
    sb.close();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hfa_pkg.sv
rtl/hfa_ctrl.sv
rtl/hfa_datapath.sv
rtl/hole_fit_allocator.sv
rtl/hfa_checker.sv
test/tb.sv
